FILE: rtl/tlbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_pkg
// Shared widths, sizes, interface structs and the page-number reduction
// function for the TLB page table translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  localparam int VA_W        = 16;
  localparam int OFF_W       = 8;
  localparam int FRAME_W     = 8;
  localparam int FREE_W      = 9;
  localparam int CNT_W       = 32;
  localparam int TLB_ENTRIES = 16;
  localparam int PAGE_COUNT  = 256;
  localparam int PAGE_W      = $clog2(PAGE_COUNT);
  localparam int TLB_IDX_W   = $clog2(TLB_ENTRIES);
  localparam int RED_W       = 16;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlbpt_hit_t;

  typedef struct packed {
    logic               en;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlbpt_wr_t;

  typedef struct packed {
    logic               mapped;
    logic [FRAME_W-1:0] frame;
  } tlbpt_pte_t;

  // Reduce a raw page number modulo PAGE_COUNT by shifted compare-subtract.
  function automatic logic [PAGE_W-1:0] page_reduce(input logic [OFF_W-1:0] raw);
    logic [RED_W-1:0] rem;
    logic [RED_W-1:0] sub;
    rem = RED_W'(raw);
    for (int k = OFF_W - 1; k >= 0; k--) begin
      sub = RED_W'(PAGE_COUNT) << k;
      if (rem >= sub) begin
        rem = rem - sub;
      end
    end
    return rem[PAGE_W-1:0];
  endfunction

endpackage

FILE: rtl/tlb_page_table_translator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlb_page_table_translator_unit
// Virtual to physical address translator with a 16-entry TLB, FIFO refill,
// page table with on-demand frame allocation, and saturating counters.
// ----------------------------------------------------------------------------
// A new word is accepted only while busy is low. The cycle that accepts a word
// searches the TLB and reads the page table memory; the next cycle resolves
// hit, mapping or fault, writes the page table and the TLB back, and busy is
// high only during that cycle. The result strobe out_valid rises in the cycle
// after busy and lasts one cycle; the receiver cannot stall, so each result
// must be taken when out_valid is high. The registered read of the
// page table memory is why each word is resolved in the busy cycle.
// ----------------------------------------------------------------------------
module tlb_page_table_translator_unit import tlbpt_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VA_W-1:0]    in_virtual_address,
  output logic               out_valid,
  output logic [VA_W-1:0]    out_physical_address,
  output logic [FRAME_W-1:0] out_frame_number,
  output logic               out_tlb_hit,
  output logic               out_page_fault,
  output logic [CNT_W-1:0]   out_hit_total,
  output logic [CNT_W-1:0]   out_fault_total,
  output logic [CNT_W-1:0]   out_translated_total
);

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

  state_t             state_r;
  logic               accept;
  logic [PAGE_W-1:0]  page_in;
  logic [PAGE_W-1:0]  page_r;
  logic [OFF_W-1:0]   offset_r;
  logic               hit_r;
  logic [FRAME_W-1:0] tlb_frame_r;
  logic [FREE_W-1:0]  next_free_r;
  logic [CNT_W-1:0]   hit_cnt_r;
  logic [CNT_W-1:0]   fault_cnt_r;
  logic [CNT_W-1:0]   xlat_cnt_r;
  logic               fault;
  logic [FRAME_W-1:0] frame;
  tlbpt_hit_t         lookup;
  tlbpt_pte_t         pte;
  tlbpt_wr_t          pt_wr;
  tlbpt_wr_t          tlb_fill;

  assign busy    = (state_r == ST_LOOKUP);
  assign accept  = start && !busy;
  assign page_in = page_reduce(in_virtual_address[VA_W-1:OFF_W]);

  tlbpt_tlb u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (page_in),
    .lookup      (lookup),
    .fill        (tlb_fill)
  );

  tlbpt_page_table u_page_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_page (page_in),
    .rd_data (pte),
    .wr      (pt_wr)
  );

  always_comb begin
    fault = !hit_r && !pte.mapped;
    if (hit_r) begin
      frame = tlb_frame_r;
    end else if (fault) begin
      frame = next_free_r[FRAME_W-1:0];
    end else begin
      frame = pte.frame;
    end
    pt_wr.en       = busy && fault;
    pt_wr.page     = page_r;
    pt_wr.frame    = frame;
    tlb_fill.en    = busy && !hit_r;
    tlb_fill.page  = page_r;
    tlb_fill.frame = frame;
  end

  // capture lookup on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r      <= page_in;
      offset_r    <= in_virtual_address[OFF_W-1:0];
      hit_r       <= lookup.hit;
      tlb_frame_r <= lookup.frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r              <= ST_IDLE;
      out_valid            <= 1'b0;
      out_physical_address <= '0;
      out_frame_number     <= '0;
      out_tlb_hit          <= 1'b0;
      out_page_fault       <= 1'b0;
      next_free_r          <= '0;
      hit_cnt_r            <= '0;
      fault_cnt_r          <= '0;
      xlat_cnt_r           <= '0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state_r              <= ST_IDLE;
          out_valid            <= 1'b1;
          out_physical_address <= {frame, offset_r};
          out_frame_number     <= frame;
          out_tlb_hit          <= hit_r;
          out_page_fault       <= fault;
          if (hit_r && (hit_cnt_r != '1)) begin
            hit_cnt_r <= hit_cnt_r + 1'b1;
          end
          if (fault) begin
            next_free_r <= next_free_r + 1'b1;
            if (fault_cnt_r != '1) begin
              fault_cnt_r <= fault_cnt_r + 1'b1;
            end
          end
          if (xlat_cnt_r != '1) begin
            xlat_cnt_r <= xlat_cnt_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_hit_total        = hit_cnt_r;
  assign out_fault_total      = fault_cnt_r;
  assign out_translated_total = xlat_cnt_r;

endmodule

FILE: rtl/tlbpt_tlb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_tlb
// Fully associative TLB with parallel tag compare, per-slot valid bits and
// FIFO refill through a wrapping fill pointer.
// ----------------------------------------------------------------------------
module tlbpt_tlb import tlbpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] lookup_page,
  output tlbpt_hit_t        lookup,
  input  tlbpt_wr_t         fill
);

  logic [PAGE_W-1:0]    tag_r   [TLB_ENTRIES];
  logic [FRAME_W-1:0]   frame_r [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_r;
  logic [TLB_IDX_W-1:0] fill_ptr_r;
  logic [TLB_IDX_W-1:0] fill_ptr_nxt;

  // lowest matching slot wins
  always_comb begin
    lookup.hit   = 1'b0;
    lookup.frame = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && (tag_r[i] == lookup_page)) begin
        lookup.hit   = 1'b1;
        lookup.frame = frame_r[i];
      end
    end
  end

  assign fill_ptr_nxt = (fill_ptr_r == TLB_IDX_W'(TLB_ENTRIES - 1)) ?
                        '0 : fill_ptr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      fill_ptr_r <= '0;
    end else if (fill.en) begin
      valid_r[fill_ptr_r] <= 1'b1;
      fill_ptr_r          <= fill_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fill.en) begin
      tag_r[fill_ptr_r]   <= fill.page;
      frame_r[fill_ptr_r] <= fill.frame;
    end
  end

endmodule

FILE: rtl/tlbpt_page_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlbpt_page_table
// Page table: synchronous frame memory with a registered read and a
// mapped bit per page, cleared at reset.
// ----------------------------------------------------------------------------
module tlbpt_page_table import tlbpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [PAGE_W-1:0] rd_page,
  output tlbpt_pte_t        rd_data,
  input  tlbpt_wr_t         wr
);

  logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];
  logic [PAGE_COUNT-1:0] mapped_r;
  logic [FRAME_W-1:0]    rd_frame_r;
  logic                  rd_mapped_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      frame_mem[wr.page] <= wr.frame;
    end
    if (rd_en) begin
      rd_frame_r <= frame_mem[rd_page];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mapped_r <= '0;
    end else if (wr.en) begin
      mapped_r[wr.page] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mapped_r <= mapped_r[rd_page];
    end
  end

  assign rd_data.mapped = rd_mapped_r;
  assign rd_data.frame  = rd_frame_r;

endmodule
